### rtl/core/ilir_pkg.sv
// ---------------------------------------------------------------------------
// Indexed list package
// Sizes, operation and status codes, and the command that is broadcast to
// every storage cell of the list.
// ---------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    localparam int CAPACITY  = 256;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 8;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 9;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int GROUP     = 16;
    localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;
    localparam int NGRP_W    = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } ilir_kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BOUNDS = 2'd1,
        STAT_FULL   = 2'd2
    } ilir_status_t;

    typedef struct packed {
        logic              ins_en;
        logic              rem_en;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } ilir_op_t;

endpackage

`default_nettype wire

### rtl/core/ilir_cell.sv
// ---------------------------------------------------------------------------
// Indexed list storage cell
// Holds one list entry. At or above the op index, an insert takes its left
// neighbour's entry or the new value; a remove takes its right neighbour's.
// ---------------------------------------------------------------------------
`default_nettype none

module ilir_cell
    import ilir_pkg::*;
(
    input  wire logic              aclk,
    input  wire ilir_op_t          op,
    input  wire logic [POS_W-1:0]  pos,
    input  wire logic [DATA_W-1:0] left_val,
    input  wire logic [DATA_W-1:0] right_val,
    output logic      [DATA_W-1:0] val,
    output logic      [DATA_W-1:0] sel_val
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  idx_c;

    assign pos_c = CMP_W'(pos);
    assign idx_c = CMP_W'(op.index);

    always_comb begin
        val_next = val_reg;
        if (op.ins_en && (pos_c > idx_c)) begin
            val_next = left_val;
        end else if (op.ins_en && (pos_c == idx_c)) begin
            val_next = op.value;
        end else if (op.rem_en && (pos_c >= idx_c)) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val     = val_reg;
    assign sel_val = (pos_c == idx_c) ? val_reg : '0;

endmodule

`default_nettype wire

### rtl/core/indexed_list_insert_remove.sv
// An accepted input beat is registered in the p1 stage, then in the output stage.
// One operation per cycle unless the output stalls; all cells shift together.
// The read path is a two-level registered OR tree over groups of 16 cells.
// Reset clears the entry count and the pipeline; entry contents are not reset.
// ---------------------------------------------------------------------------
// Indexed list with insert and remove
// A fixed-capacity ordered list built from a chain of storage cells, with
// get, insert-at-index and remove-at-index operations.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove
    import ilir_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // index [7:0], value [39:8]
    input  wire logic [1:0]  s_tuser,   // kind [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // read_value [31:0], count [40:32], zeros
    output logic      [1:0]  m_tuser    // status [1:0]
);

    logic              s_accept;
    logic              p1_adv;
    ilir_kind_t        kind;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [CMP_W-1:0]  idx_c;
    logic [CMP_W-1:0]  cnt_c;
    logic              in_range;
    logic              ins_ok;
    ilir_op_t          op;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    ilir_status_t      status_next;
    logic              rd_next;

    logic              p1_valid_reg;
    logic              p1_rd_reg;
    ilir_status_t      p1_status_reg;
    logic [CNT_W-1:0]  p1_count_reg;
    logic [DATA_W-1:0] grp_reg [NGROUPS];

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    ilir_status_t      m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic [DATA_W-1:0] tree_or;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] sel_val  [NGROUPS*GROUP];

    assign kind  = ilir_kind_t'(s_tuser);
    assign index = s_tdata[IDX_W-1:0];
    assign value = s_tdata[IDX_W +: DATA_W];
    assign idx_c = CMP_W'(index);
    assign cnt_c = CMP_W'(count_reg);

    assign in_range = idx_c < cnt_c;
    assign ins_ok   = (idx_c <= cnt_c) && (count_reg < CNT_W'(CAPACITY));

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        count_next  = count_reg;
        status_next = STAT_OK;
        rd_next     = 1'b0;
        op.ins_en   = 1'b0;
        op.rem_en   = 1'b0;
        op.index    = index;
        op.value    = value;
        case (kind)
            KIND_GET: begin
                if (in_range) begin
                    rd_next = 1'b1;
                end else begin
                    status_next = STAT_BOUNDS;
                end
            end
            KIND_INSERT: begin
                if (idx_c > cnt_c) begin
                    status_next = STAT_BOUNDS;
                end else if (!ins_ok) begin
                    status_next = STAT_FULL;
                end else begin
                    op.ins_en  = s_accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (in_range) begin
                    rd_next    = 1'b1;
                    op.rem_en  = s_accept;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = STAT_BOUNDS;
                end
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ilir_cell u_cell (
                .aclk      (aclk),
                .op        (op),
                .pos       (POS_W'(g)),
                .left_val  ((g == 0) ? '0 : cell_val[(g == 0) ? 0 : g - 1]),
                .right_val ((g == CAPACITY - 1) ? '0
                            : cell_val[(g == CAPACITY - 1) ? g : g + 1]),
                .val       (cell_val[g]),
                .sel_val   (sel_val[g])
            );
        end
        for (g = CAPACITY; g < NGROUPS*GROUP; g++) begin : g_pad
            assign sel_val[g] = '0;
        end
        for (g = 0; g < NGROUPS; g++) begin : g_grp
            logic [DATA_W-1:0] grp_or;
            always_comb begin
                grp_or = '0;
                for (int k = 0; k < GROUP; k++) begin
                    grp_or = grp_or | sel_val[g*GROUP + k];
                end
            end
            always_ff @(posedge aclk) begin
                if (s_accept) begin
                    grp_reg[g] <= grp_or;
                end
            end
        end
    endgenerate

    always_comb begin
        tree_or = '0;
        for (int k = 0; k < NGROUPS; k++) begin
            tree_or = tree_or | grp_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg <= count_next;
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_rd_reg     <= rd_next;
            p1_status_reg <= status_next;
            p1_count_reg  <= count_next;
        end
        if (p1_adv) begin
            m_value_reg  <= p1_rd_reg ? tree_or : '0;
            m_status_reg <= p1_status_reg;
            m_count_reg  <= p1_count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, OUT_CNT_W'(m_count_reg), m_value_reg};

endmodule

`default_nettype wire

### rtl/core/ilir_checker.sv
// ---------------------------------------------------------------------------
// Indexed list port checker
// Watches the ports of the indexed list and checks its results over time.
// ---------------------------------------------------------------------------
`default_nettype none

module ilir_checker
    import ilir_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    logic unused_ok;
    assign unused_ok = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("Result beat changed while stalled.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_BOUNDS || m_tuser == STAT_FULL))
        else $error("Result beat carries an unknown status.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[31:0] == '0))
        else $error("Failed operation returned a non-zero value.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[40:32] == OUT_CNT_W'(CAPACITY)))
        else $error("List reported full below capacity.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:41] == '0))
        else $error("Result padding bits are not zero.");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (.*);

`default_nettype wire
